// ===== rtl/core/alm_pkg.sv =====
// Shared types, constants and codes of the array linked list manager.
package alm_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = 6;
    localparam int LINK_W   = 7;
    localparam int CNT_W    = 7;
    localparam logic [LINK_W-1:0] NIL = 7'd127;

    // Request codes
    localparam logic [1:0] REQ_HEAD = 2'd0;
    localparam logic [1:0] REQ_SLOT = 2'd1;
    localparam logic [1:0] REQ_DUMP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    // Read address select
    localparam logic [1:0] RD_FREE = 2'd0;
    localparam logic [1:0] RD_SLOT = 2'd1;
    localparam logic [1:0] RD_WALK = 2'd2;

    // Write source select
    localparam logic [1:0] WR_HEAD = 2'd0;
    localparam logic [1:0] WR_MOVE = 2'd1;
    localparam logic [1:0] WR_SLOT = 2'd2;

    // Result kind select
    localparam logic [1:0] EM_FAIL = 2'd0;
    localparam logic [1:0] EM_HEAD = 2'd1;
    localparam logic [1:0] EM_SLOT = 2'd2;
    localparam logic [1:0] EM_DUMP = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  slot;
        logic signed [31:0] key;
        logic signed [31:0] info;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  node_index;
        logic signed [31:0] key_out;
        logic signed [31:0] info_out;
        logic [CNT_W-1:0]  element_count;
        logic              last;
    } t_rsp;

    typedef struct packed {
        logic       latch;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       take_free;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       walk_start;
        logic       walk_adv;
        logic       emit;
        logic [1:0] em_kind;
        logic [1:0] em_status;
        logic       em_last;
    } t_cmd;

    typedef struct packed {
        logic free_nil;
        logic head_nil;
        logic count_zero;
        logic slot_member;
        logic link_nil;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/alm_ctrl.sv =====
// Controller state machine of the array linked list manager.
module alm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_req_type,
    input  alm_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output alm_pkg::t_cmd o_cmd
);

    localparam int IDX_W = alm_pkg::IDX_W;
    localparam logic [IDX_W-1:0] K_LAST = IDX_W'(alm_pkg::CAPACITY - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_H_RD   = 4'd1;
    localparam logic [3:0] S_H_TAKE = 4'd2;
    localparam logic [3:0] S_H_WR   = 4'd3;
    localparam logic [3:0] S_S_RD   = 4'd4;
    localparam logic [3:0] S_S_TAKE = 4'd5;
    localparam logic [3:0] S_S_MOVE = 4'd6;
    localparam logic [3:0] S_S_WR   = 4'd7;
    localparam logic [3:0] S_D_RD   = 4'd8;
    localparam logic [3:0] S_D_EMIT = 4'd9;
    localparam logic [3:0] S_FAIL   = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_fail_st, n_fail_st;
    logic [IDX_W-1:0] r_k, n_k;
    logic             w_last;

    // Hold state, failure code and walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fail_st <= alm_pkg::ST_OK;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_fail_st <= n_fail_st;
            r_k       <= n_k;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_last     = i_sts.link_nil || (r_k == K_LAST);

    // Sequence each request through its memory steps
    always_comb begin
        n_state   = r_state;
        n_fail_st = r_fail_st;
        n_k       = r_k;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_req_type)
                        alm_pkg::REQ_HEAD: begin
                            if (i_sts.free_nil) begin
                                n_fail_st = alm_pkg::ST_NOFREE;
                                n_state   = S_FAIL;
                            end else begin
                                n_state = S_H_RD;
                            end
                        end
                        alm_pkg::REQ_SLOT: begin
                            if (i_sts.count_zero) begin
                                n_fail_st = alm_pkg::ST_EMPTY;
                                n_state   = S_FAIL;
                            end else if (i_sts.free_nil) begin
                                n_fail_st = alm_pkg::ST_NOFREE;
                                n_state   = S_FAIL;
                            end else if (!i_sts.slot_member) begin
                                n_fail_st = alm_pkg::ST_EMPTY;
                                n_state   = S_FAIL;
                            end else begin
                                n_state = S_S_RD;
                            end
                        end
                        alm_pkg::REQ_DUMP: begin
                            if (i_sts.head_nil) begin
                                n_fail_st = alm_pkg::ST_EMPTY;
                                n_state   = S_FAIL;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                n_k              = '0;
                                n_state          = S_D_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_H_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = alm_pkg::RD_FREE;
                n_state      = S_H_TAKE;
            end
            S_H_TAKE: begin
                o_cmd.take_free = 1'b1;
                n_state         = S_H_WR;
            end
            S_H_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_sel    = alm_pkg::WR_HEAD;
                    o_cmd.emit      = 1'b1;
                    o_cmd.em_kind   = alm_pkg::EM_HEAD;
                    o_cmd.em_status = alm_pkg::ST_OK;
                    o_cmd.em_last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_S_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = alm_pkg::RD_FREE;
                n_state      = S_S_TAKE;
            end
            S_S_TAKE: begin
                o_cmd.take_free = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = alm_pkg::RD_SLOT;
                n_state         = S_S_MOVE;
            end
            S_S_MOVE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = alm_pkg::WR_MOVE;
                n_state      = S_S_WR;
            end
            S_S_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_sel    = alm_pkg::WR_SLOT;
                    o_cmd.emit      = 1'b1;
                    o_cmd.em_kind   = alm_pkg::EM_SLOT;
                    o_cmd.em_status = alm_pkg::ST_OK;
                    o_cmd.em_last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_D_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = alm_pkg::RD_WALK;
                n_state      = S_D_EMIT;
            end
            S_D_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.em_kind   = alm_pkg::EM_DUMP;
                    o_cmd.em_status = alm_pkg::ST_OK;
                    o_cmd.em_last   = w_last;
                    o_cmd.walk_adv  = 1'b1;
                    n_k             = r_k + IDX_W'(1);
                    n_state         = w_last ? S_IDLE : S_D_RD;
                end
            end
            S_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.em_kind   = alm_pkg::EM_FAIL;
                    o_cmd.em_status = r_fail_st;
                    o_cmd.em_last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/alm_dpath.sv =====
// Datapath of the array linked list manager: node stores, pointers, result register.
module alm_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  alm_pkg::t_req i_req,
    input  alm_pkg::t_cmd i_cmd,
    input  logic          i_out_stall,
    output alm_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output alm_pkg::t_rsp o_out_data
);

    localparam int CAPACITY = alm_pkg::CAPACITY;
    localparam int IDX_W    = alm_pkg::IDX_W;
    localparam int LINK_W   = alm_pkg::LINK_W;
    localparam int CNT_W    = alm_pkg::CNT_W;

    // Link value of a node right after reset
    function automatic logic [LINK_W-1:0] f_link_init(input logic [IDX_W-1:0] a);
        logic [LINK_W-1:0] v;
        if (a == IDX_W'(CAPACITY - 1)) begin
            v = alm_pkg::NIL;
        end else begin
            v = LINK_W'(a) + LINK_W'(1);
        end
        return v;
    endfunction

    logic [31:0]       m_key  [CAPACITY];
    logic [31:0]       m_info [CAPACITY];
    logic [LINK_W-1:0] m_link [CAPACITY];
    logic [CAPACITY-1:0] r_link_vld;
    logic [CAPACITY-1:0] r_member;

    logic [IDX_W-1:0]  r_slot;
    logic [31:0]       r_key;
    logic [31:0]       r_info;
    logic [LINK_W-1:0] r_head;
    logic [LINK_W-1:0] r_free;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_node;
    logic [LINK_W-1:0] r_walk;

    logic [31:0]       r_key_rd;
    logic [31:0]       r_info_rd;
    logic [LINK_W-1:0] r_link_rd;

    logic              r_out_valid;
    alm_pkg::t_rsp     r_out;

    logic [IDX_W-1:0]  w_rd_addr;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [31:0]       w_wr_key;
    logic [31:0]       w_wr_info;
    logic [LINK_W-1:0] w_wr_link;
    logic              w_wr_member;
    logic              w_out_free;
    alm_pkg::t_rsp     w_rsp;

    // Select read address
    always_comb begin
        case (i_cmd.rd_sel)
            alm_pkg::RD_FREE: w_rd_addr = r_free[IDX_W-1:0];
            alm_pkg::RD_SLOT: w_rd_addr = r_slot;
            default:          w_rd_addr = r_walk[IDX_W-1:0];
        endcase
    end

    // Select write address and data
    always_comb begin
        case (i_cmd.wr_sel)
            alm_pkg::WR_HEAD: begin
                w_wr_addr   = r_node;
                w_wr_key    = r_key;
                w_wr_info   = r_info;
                w_wr_link   = r_head;
                w_wr_member = 1'b1;
            end
            alm_pkg::WR_MOVE: begin
                w_wr_addr   = r_node;
                w_wr_key    = r_key_rd;
                w_wr_info   = r_info_rd;
                w_wr_link   = r_link_rd;
                w_wr_member = 1'b1;
            end
            default: begin
                w_wr_addr   = r_slot;
                w_wr_key    = r_key;
                w_wr_info   = r_info;
                w_wr_link   = LINK_W'(r_node);
                w_wr_member = 1'b0;
            end
        endcase
    end

    // Write and read key and info stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            m_key[w_wr_addr]  <= w_wr_key;
            m_info[w_wr_addr] <= w_wr_info;
        end
        if (i_cmd.rd_en) begin
            r_key_rd  <= m_key[w_rd_addr];
            r_info_rd <= m_info[w_rd_addr];
        end
    end

    // Write and read link store; an unwritten entry reads as its reset link
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            m_link[w_wr_addr] <= w_wr_link;
        end
        if (i_cmd.rd_en) begin
            r_link_rd <= r_link_vld[w_rd_addr] ? m_link[w_rd_addr]
                                               : f_link_init(w_rd_addr);
        end
    end

    // Track written links and list membership
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_member   <= '0;
        end else if (i_cmd.wr_en) begin
            r_link_vld[w_wr_addr] <= 1'b1;
            if (w_wr_member) begin
                r_member[w_wr_addr] <= 1'b1;
            end
        end
    end

    // Capture request fields on an input transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_slot <= i_req.slot;
            r_key  <= i_req.key;
            r_info <= i_req.info;
        end
    end

    // Update head, free pointer, count, taken node and walk pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= alm_pkg::NIL;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.take_free) begin
                r_free <= r_link_rd;
            end
            if (i_cmd.wr_en && (i_cmd.wr_sel == alm_pkg::WR_HEAD)) begin
                r_head <= LINK_W'(r_node);
            end
            if (i_cmd.wr_en && ((i_cmd.wr_sel == alm_pkg::WR_HEAD) ||
                                (i_cmd.wr_sel == alm_pkg::WR_SLOT))) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_free) begin
            r_node <= r_free[IDX_W-1:0];
        end
        if (i_cmd.walk_start) begin
            r_walk <= r_head;
        end else if (i_cmd.walk_adv) begin
            r_walk <= r_link_rd;
        end
    end

    // Build the result of the current step
    always_comb begin
        w_rsp        = '0;
        w_rsp.status = i_cmd.em_status;
        w_rsp.last   = i_cmd.em_last;
        w_rsp.element_count = r_count;
        case (i_cmd.em_kind)
            alm_pkg::EM_HEAD: begin
                w_rsp.node_index    = r_node;
                w_rsp.element_count = r_count + CNT_W'(1);
            end
            alm_pkg::EM_SLOT: begin
                w_rsp.node_index    = r_slot;
                w_rsp.element_count = r_count + CNT_W'(1);
            end
            alm_pkg::EM_DUMP: begin
                w_rsp.node_index = r_walk[IDX_W-1:0];
                w_rsp.key_out    = r_key_rd;
                w_rsp.info_out   = r_info_rd;
            end
            default: begin
                w_rsp.node_index = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Hold the result until the receiver takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Report status to the controller
    assign o_sts.free_nil    = r_free[LINK_W-1];
    assign o_sts.head_nil    = r_head[LINK_W-1];
    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.slot_member = r_member[i_req.slot];
    assign o_sts.link_nil    = r_link_rd[LINK_W-1];
    assign o_sts.out_free    = w_out_free;

endmodule

// ===== rtl/core/array_linked_list_manager.sv =====
// Top level of the array linked list manager: node pool with a list and a free list.
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_data) carries one request per
//   transaction: insert at head, insert before a slot, or dump the list.
//   Output channel (o_out_valid, i_out_stall, o_out_data) returns results.
//   Each insert gives one result; a dump gives one result per list element,
//   or one status result for an empty list; the final result has last set.
//   Requests run one at a time; o_in_stall is high while one is in work.
//   Head insert steps from accept to result: free link read, pop, write.
//   Slot insert steps: free link read, pop plus slot read, move, write.
//   Failed insert or empty dump: a single status result step after accept.
//   Dump: each element takes a registered read of the node stores on the
//   walk, then its result; the next request is taken the cycle after the last.
//   Unused request code 3 is consumed with no result.
//   A result waits in an output register while i_out_stall is high; the
//   next request is still accepted, and work stalls only when a new result
//   is ready and the register is still full.
//   Reset (synchronous, active low) empties the list and chains every node
//   as free at once through per-node link valid bits; no clearing pass.
module array_linked_list_manager (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  alm_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output alm_pkg::t_rsp o_out_data
);

    alm_pkg::t_cmd w_cmd;
    alm_pkg::t_sts w_sts;

    // Sequence requests
    alm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Store nodes and build results
    alm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/tb_array_linked_list_manager.sv =====
// Testbench for the array linked list manager: directed and random requests vs a predictor.
`timescale 1ns / 100ps

module tb_array_linked_list_manager;

    localparam int CAPACITY = alm_pkg::CAPACITY;
    localparam int IDX_W    = alm_pkg::IDX_W;
    localparam int LINK_W   = alm_pkg::LINK_W;
    localparam int CNT_W    = alm_pkg::CNT_W;

    localparam logic [1:0] REQ_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         DONE_WAIT   = 20;
    localparam int         RANDOM_REQS = 300;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        alm_pkg::t_req req;
        logic          typed;
        alm_pkg::t_rsp want;
    } t_step;

    // Directed walk; rows with typed set carry a hand-written single result
    localparam int PLAN_LEN = 16;
    localparam t_step PLAN [PLAN_LEN] = '{
        // dump and slot inserts on the empty list
        '{'{alm_pkg::REQ_DUMP, 6'd0, 32'h0, 32'h0}, 1'b1,
          '{alm_pkg::ST_EMPTY, 6'd0, 32'h0, 32'h0, 7'd0, 1'b1}},
        '{'{alm_pkg::REQ_SLOT, 6'd0, 32'h1, 32'h2}, 1'b1,
          '{alm_pkg::ST_EMPTY, 6'd0, 32'h0, 32'h0, 7'd0, 1'b1}},
        '{'{alm_pkg::REQ_SLOT, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
          '{alm_pkg::ST_EMPTY, 6'd0, 32'h0, 32'h0, 7'd0, 1'b1}},
        // unused code gives nothing
        '{'{REQ_SPARE, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
        // head inserts with extreme keys and payloads
        '{'{alm_pkg::REQ_HEAD, 6'd0, 32'h7FFFFFFF, 32'h80000000}, 1'b1,
          '{alm_pkg::ST_OK, 6'd0, 32'h0, 32'h0, 7'd1, 1'b1}},
        '{'{alm_pkg::REQ_HEAD, 6'd0, 32'h80000000, 32'h7FFFFFFF}, 1'b1,
          '{alm_pkg::ST_OK, 6'd1, 32'h0, 32'h0, 7'd2, 1'b1}},
        '{'{alm_pkg::REQ_DUMP, 6'd0, 32'h0, 32'h0}, 1'b0, '0},
        // insert before the tail node, then try a free node as slot
        '{'{alm_pkg::REQ_SLOT, 6'd0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
          '{alm_pkg::ST_OK, 6'd0, 32'h0, 32'h0, 7'd3, 1'b1}},
        '{'{alm_pkg::REQ_SLOT, 6'd63, 32'h0, 32'h0}, 1'b1,
          '{alm_pkg::ST_EMPTY, 6'd0, 32'h0, 32'h0, 7'd3, 1'b1}},
        '{'{alm_pkg::REQ_SLOT, 6'd2, 32'h0, 32'h0}, 1'b0, '0},
        '{'{alm_pkg::REQ_HEAD, 6'd0, 32'h55555555, 32'hAAAAAAAA}, 1'b0, '0},
        '{'{alm_pkg::REQ_HEAD, 6'd0, 32'hAAAAAAAA, 32'h55555555}, 1'b0, '0},
        '{'{alm_pkg::REQ_SLOT, 6'd1, 32'h1, 32'hFFFFFFFE}, 1'b0, '0},
        '{'{REQ_SPARE, 6'd0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{alm_pkg::REQ_DUMP, 6'd42, 32'h0, 32'h0}, 1'b0, '0},
        '{'{alm_pkg::REQ_SLOT, 6'd42, 32'h12345678, 32'h9ABCDEF0}, 1'b0, '0}
    };

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_out_stall = 1'b0;
    alm_pkg::t_req i_in_data   = '0;
    logic          o_in_stall;
    logic          o_out_valid;
    alm_pkg::t_rsp o_out_data;

    // Predicted list state
    logic signed [31:0] key_mem  [CAPACITY];
    logic signed [31:0] info_mem [CAPACITY];
    logic [LINK_W-1:0]  link_mem [CAPACITY];
    logic               on_list  [CAPACITY];
    logic [LINK_W-1:0]  head_idx;
    logic [LINK_W-1:0]  free_idx;
    logic [CNT_W-1:0]   elem_count;

    alm_pkg::t_rsp results_owed [$];
    alm_pkg::t_rsp want_rsp;
    int            mismatches = 0;
    logic          steady     = 1'b0;

    array_linked_list_manager uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the predicted list and queue the results it owes
    function automatic void list_apply(input alm_pkg::t_req r);
        alm_pkg::t_rsp     res;
        logic [LINK_W-1:0] n;
        logic [IDX_W-1:0]  a;
        logic [LINK_W-1:0] p;
        logic [IDX_W-1:0]  pa;
        logic [LINK_W-1:0] nx;
        int                k;
        res      = '0;
        res.last = 1'b1;
        case (r.req_type)
            alm_pkg::REQ_HEAD: begin
                if (free_idx >= CAPACITY) begin
                    res.status = alm_pkg::ST_NOFREE;
                end else begin
                    n              = free_idx;
                    a              = n[IDX_W-1:0];
                    free_idx       = link_mem[a];
                    key_mem[a]     = r.key;
                    info_mem[a]    = r.info;
                    link_mem[a]    = head_idx;
                    on_list[a]     = 1'b1;
                    head_idx       = n;
                    elem_count     = elem_count + 1'b1;
                    res.node_index = a;
                end
                res.element_count = elem_count;
                results_owed.push_back(res);
            end
            alm_pkg::REQ_SLOT: begin
                if (elem_count == 0) begin
                    res.status = alm_pkg::ST_EMPTY;
                end else if (free_idx >= CAPACITY) begin
                    res.status = alm_pkg::ST_NOFREE;
                end else if (!on_list[r.slot]) begin
                    res.status = alm_pkg::ST_EMPTY;
                end else begin
                    // move the slot's entry into a fresh node, new entry takes the slot
                    n                 = free_idx;
                    a                 = n[IDX_W-1:0];
                    free_idx          = link_mem[a];
                    key_mem[a]        = key_mem[r.slot];
                    info_mem[a]       = info_mem[r.slot];
                    link_mem[a]       = link_mem[r.slot];
                    on_list[a]        = 1'b1;
                    key_mem[r.slot]   = r.key;
                    info_mem[r.slot]  = r.info;
                    link_mem[r.slot]  = n;
                    elem_count        = elem_count + 1'b1;
                    res.node_index    = r.slot;
                end
                res.element_count = elem_count;
                results_owed.push_back(res);
            end
            alm_pkg::REQ_DUMP: begin
                res.element_count = elem_count;
                if (head_idx >= CAPACITY) begin
                    res.status = alm_pkg::ST_EMPTY;
                    results_owed.push_back(res);
                end else begin
                    // walk from the head, one result per element
                    p = head_idx;
                    k = 0;
                    while (p < CAPACITY && k < CAPACITY) begin
                        pa             = p[IDX_W-1:0];
                        nx             = link_mem[pa];
                        res.node_index = pa;
                        res.key_out    = key_mem[pa];
                        res.info_out   = info_mem[pa];
                        res.last       = (nx >= CAPACITY) || (k == CAPACITY - 1);
                        results_owed.push_back(res);
                        k++;
                        p = nx;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Mostly random words, now and then an extreme
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: w = 32'h7FFFFFFF;
                1: w = 32'h80000000;
                2: w = 32'h00000000;
                default: w = 32'hFFFFFFFF;
            endcase
        end
        return w;
    endfunction

    // Present one transaction from the falling edge and hold it until accepted
    task automatic send_request(input alm_pkg::t_req r, input logic typed,
                                input alm_pkg::t_rsp want);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        list_apply(r);
        // a typed row swaps its single predicted result for the written one
        if (typed) begin
            void'(results_owed.pop_back());
            results_owed.push_back(want);
        end
    endtask

    task automatic note_mismatch(input string what, input alm_pkg::t_rsp want,
                                 input alm_pkg::t_rsp got);
        if (mismatches < REPORT_MAX) begin
            $display("%0t %s: want st=%0d idx=%0d key=%h info=%h cnt=%0d last=%0d",
                     $time, what, want.status, want.node_index, want.key_out,
                     want.info_out, want.element_count, want.last);
            $display("%0t %s: got  st=%0d idx=%0d key=%h info=%h cnt=%0d last=%0d",
                     $time, what, got.status, got.node_index, got.key_out,
                     got.info_out, got.element_count, got.last);
        end
        mismatches++;
    endtask

    // Stall the result side at random outside the steady stretch
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 7);
    end

    // Check each accepted result against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_owed.size() == 0) begin
                note_mismatch("unexpected result", '0, o_out_data);
            end else begin
                want_rsp = results_owed.pop_front();
                if (o_out_data.status !== want_rsp.status
                        || o_out_data.node_index !== want_rsp.node_index
                        || o_out_data.key_out !== want_rsp.key_out
                        || o_out_data.info_out !== want_rsp.info_out
                        || o_out_data.element_count !== want_rsp.element_count
                        || o_out_data.last !== want_rsp.last) begin
                    note_mismatch("result mismatch", want_rsp, o_out_data);
                end
            end
        end
    end

    // Hard stop on a hang
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("array_linked_list_manager: mismatch");
        $finish;
    end

    initial begin
        alm_pkg::t_req    r;
        int               pick;
        int               sent;
        logic [IDX_W-1:0] s;

        // Predicted state after reset: every node free in index order
        for (int i = 0; i < CAPACITY; i++) begin
            key_mem[IDX_W'(i)]  = '0;
            info_mem[IDX_W'(i)] = '0;
            link_mem[IDX_W'(i)] = LINK_W'(i + 1);
            on_list[IDX_W'(i)]  = 1'b0;
        end
        link_mem[CAPACITY-1] = alm_pkg::NIL;
        head_idx   = alm_pkg::NIL;
        free_idx   = '0;
        elem_count = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk
        for (int i = 0; i < PLAN_LEN; i++) begin
            send_request(PLAN[i].req, PLAN[i].typed, PLAN[i].want);
        end

        // Random walk: mostly inserts, enough to fill the pool, dumps throughout
        sent = 0;
        while (sent < RANDOM_REQS) begin
            steady = (sent >= 100) && (sent < 160);
            pick   = $urandom_range(99);
            r.slot = IDX_W'($urandom_range(CAPACITY - 1));
            r.key  = pick_word();
            r.info = pick_word();
            if (pick < 5) begin
                r.req_type = REQ_SPARE;
            end else if (pick < 20) begin
                r.req_type = alm_pkg::REQ_DUMP;
            end else if (pick < 55) begin
                r.req_type = alm_pkg::REQ_HEAD;
            end else begin
                r.req_type = alm_pkg::REQ_SLOT;
                if (pick < 88 && elem_count != 0) begin
                    do s = IDX_W'($urandom_range(CAPACITY - 1)); while (!on_list[s]);
                    r.slot = s;
                end
            end
            send_request(r, 1'b0, '0);
            if (r.req_type != REQ_SPARE) begin
                sent++;
            end
        end
        steady = 1'b0;

        // Drain and let any trailing work settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_owed.size() != 0) @(posedge i_clk);
        repeat (DONE_WAIT) @(posedge i_clk);
        mismatches += results_owed.size();

        if (mismatches == 0) begin
            $display("array_linked_list_manager: match");
        end else begin
            $display("array_linked_list_manager: mismatch");
        end
        $finish;
    end

endmodule
